// ===== rtl/pwm_prescaler_period_solver_defines.svh =====
// Assertion macros for the PWM prescaler and period solver.
`ifndef PWM_PRESCALER_PERIOD_SOLVER_DEFINES_SVH
`define PWM_PRESCALER_PERIOD_SOLVER_DEFINES_SVH
`ifndef SYNTHESIS
`define PPS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PPS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPS_ASSERT(name, clk, rst, prop, msg)
`define PPS_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// ===== rtl/pps_pkg.sv =====
// Shared types and constants of the PWM prescaler and period solver.
package pps_pkg;
   localparam int DIV_W = 40;
   localparam int CSR_W = 29;

   localparam logic [29:0] SCALE_NS = 30'd1000000000;
   localparam logic [29:0] SCALE_US = 30'd1000000;
   localparam logic [29:0] SCALE_MS = 30'd1000;
   localparam logic [28:0] MEGA     = 29'd1000000;

   typedef enum logic [1:0] {
      CSR_TIMER_CLOCK = 2'd0,
      CSR_MAX_CLOCK   = 2'd1,
      CSR_TIMER_32BIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             go;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quo;
   } div_rsp_type;

   typedef enum logic [14:0] {
      S_IDLE  = 15'b000000000000001,
      S_TGT   = 15'b000000000000010,
      S_PRE   = 15'b000000000000100,
      S_MHZ   = 15'b000000000001000,
      S_SMALL = 15'b000000000010000,
      S_PDIV  = 15'b000000000100000,
      S_HALF  = 15'b000000001000000,
      S_W16   = 15'b000000010000000,
      S_A     = 15'b000000100000000,
      S_D     = 15'b000001000000000,
      S_PER   = 15'b000010000000000,
      S_ACT   = 15'b000100000000000,
      S_CHECK = 15'b001000000000000,
      S_AD    = 15'b010000000000000,
      S_OUT   = 15'b100000000000000
   } state_type;
endpackage

// ===== rtl/pps_channels.sv =====
// Handshake channel interfaces for request and response items.
interface pps_req_if;
   logic        valid;
   logic        ready;
   logic [35:0] desired_freq_q8;
   modport source (output valid, output desired_freq_q8, input ready);
   modport sink (input valid, input desired_freq_q8, output ready);
endinterface

interface pps_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] prescaler;
   logic [31:0] period_count;
   logic [29:0] actual_freq_hz;
   logic        ok;
   modport source (output valid, output prescaler, output period_count,
                   output actual_freq_hz, output ok, input ready);
   modport sink (input valid, input prescaler, input period_count,
                 input actual_freq_hz, input ok, output ready);
endinterface

// ===== rtl/pps_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
module pps_divider import pps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req_i,
   output div_rsp_type rsp_o
);
   localparam int CW = $clog2(DIV_W);

   logic [DIV_W-1:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DIV_W:0]   trial, diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req_i.go) begin
         rem_in  = '0;
         quo_in  = req_i.num;
         den_in  = req_i.den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp_o.done = done_ff;
   assign rsp_o.quo  = quo_ff;
endmodule

// ===== rtl/pwm_prescaler_period_solver.sv =====
// Top level of the PWM prescaler and period solver.
//
//   Port   Direction  Carries
//   req    in         desired frequency, unsigned Q28.8 hertz
//   rsp    out        prescaler, period count, achieved frequency, ok flag
//   csr    in         timer clock, largest chip clock, counter width
//
// One item at a time. Each division runs on the shared divider; an item needs six to
// eight of them besides the halving, doubling and check steps, and each extra pass
// of the period search adds four more divisions.
// Reset is synchronous and loads the default register values.
// The result is held in rsp until taken, and req is ready only when idle.
`include "pwm_prescaler_period_solver_defines.svh"
module pwm_prescaler_period_solver import pps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   pps_req_if.sink           req,
   pps_rsp_if.source         rsp,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);
   state_type   state_ff, state_in;
   logic [28:0] clk_ff;
   logic [8:0]  maxm_ff;
   logic        is32_ff;
   logic [35:0] q_ff, q_in;
   logic [29:0] scale_ff, scale_in;
   logic [31:0] target_ff, target_in, p_ff, p_in;
   logic [19:0] pre_ff, pre_in;
   logic [9:0]  mhz_ff, mhz_in;
   logic [28:0] a_ff, a_in, d_ff, d_in;
   logic [29:0] per2_ff, per2_in, act_ff, act_in;
   logic [41:0] prod_ff, prod_in;
   logic        big_ff, big_in, ok_ff, ok_in;
   div_req_type dreq_ff, dreq_in;
   div_rsp_type dresp;
   logic [DIV_W-1:0] qv;
   logic [40:0] prod_max;
   logic [29:0] scale_v;
   logic        fail;
   logic        rsp_set;
   logic        rsp_zero;
   logic        div_wait;

   pps_divider u_div (.clock(clock), .reset(reset), .req_i(dreq_ff), .rsp_o(dresp));

   assign qv       = dresp.quo;
   assign prod_max = 41'(p_ff) * 41'(maxm_ff);

   always_comb begin
      if (req.desired_freq_q8 >= 36'd256000) begin
         scale_v = SCALE_NS;
      end else if (req.desired_freq_q8 >= 36'd256) begin
         scale_v = SCALE_US;
      end else begin
         scale_v = SCALE_MS;
      end
   end

   always_comb begin
      state_in  = state_ff;
      q_in      = q_ff;
      scale_in  = scale_ff;
      target_in = target_ff;
      p_in      = p_ff;
      pre_in    = pre_ff;
      mhz_in    = mhz_ff;
      a_in      = a_ff;
      d_in      = d_ff;
      per2_in   = per2_ff;
      act_in    = act_ff;
      prod_in   = prod_ff;
      big_in    = big_ff;
      ok_in     = ok_ff;
      dreq_in   = '{go: 1'b0, num: dreq_ff.num, den: dreq_ff.den};
      fail      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               q_in     = req.desired_freq_q8;
               scale_in = scale_v;
               if (req.desired_freq_q8 == '0) begin
                  fail = 1'b1;
               end else begin
                  dreq_in  = '{go: 1'b1,
                     num: DIV_W'({scale_v, 9'b0}) + DIV_W'(req.desired_freq_q8),
                     den: DIV_W'({req.desired_freq_q8, 1'b0})};
                  state_in = S_TGT;
               end
            end
         end
         S_TGT: begin
            if (dresp.done) begin
               target_in = qv[31:0];
               p_in      = qv[31:0];
               dreq_in   = '{go: 1'b1, num: DIV_W'(clk_ff), den: DIV_W'(scale_ff)};
               state_in  = S_PRE;
            end
         end
         S_PRE: begin
            if (dresp.done) begin
               pre_in = qv[19:0];
               if (qv == '0) begin
                  dreq_in  = '{go: 1'b1, num: DIV_W'(clk_ff), den: DIV_W'(MEGA)};
                  state_in = S_MHZ;
               end else begin
                  state_in = S_HALF;
               end
            end
         end
         S_MHZ: begin
            if (dresp.done) begin
               mhz_in = qv[9:0];
               if (maxm_ff == '0 || scale_ff == SCALE_MS) begin
                  fail = 1'b1;
               end else begin
                  big_in   = prod_max > 41'h0FFFFFFFF;
                  prod_in  = 42'(p_ff) * 42'(qv[9:0]);
                  state_in = S_SMALL;
               end
            end
         end
         S_SMALL: begin
            if (big_ff) begin
               pre_in = 20'(mhz_ff);
               if (scale_ff == SCALE_NS) begin
                  dreq_in  = '{go: 1'b1, num: DIV_W'(p_ff), den: DIV_W'(SCALE_MS)};
                  state_in = S_PDIV;
               end else begin
                  state_in = S_W16;
               end
            end else if (prod_ff[41:32] != '0) begin
               fail = 1'b1;
            end else begin
               pre_in = 20'd1;
               if (scale_ff == SCALE_NS) begin
                  dreq_in  = '{go: 1'b1, num: DIV_W'(prod_ff[31:0]),
                               den: DIV_W'(SCALE_MS)};
                  state_in = S_PDIV;
               end else begin
                  p_in     = prod_ff[31:0];
                  state_in = S_W16;
               end
            end
         end
         S_PDIV: begin
            if (dresp.done) begin
               p_in     = qv[31:0];
               state_in = S_W16;
            end
         end
         S_HALF: begin
            if (pre_ff > 20'h10000) begin
               if (p_ff >= 32'h80000000) begin
                  fail = 1'b1;
               end else begin
                  pre_in = pre_ff >> 1;
                  p_in   = p_ff << 1;
               end
            end else begin
               state_in = S_W16;
            end
         end
         S_W16: begin
            if (!is32_ff && p_ff >= 32'h10000) begin
               if (pre_ff > 20'h8000) begin
                  fail = 1'b1;
               end else begin
                  pre_in = pre_ff << 1;
                  p_in   = p_ff >> 1;
               end
            end else if (p_ff == '0 || pre_ff == '0) begin
               fail = 1'b1;
            end else begin
               dreq_in  = '{go: 1'b1, num: DIV_W'(clk_ff), den: DIV_W'(pre_ff)};
               state_in = S_A;
            end
         end
         S_A: begin
            if (dresp.done) begin
               a_in     = qv[28:0];
               dreq_in  = '{go: 1'b1, num: DIV_W'(qv[28:0]), den: DIV_W'(p_ff)};
               state_in = S_D;
            end
         end
         S_D: begin
            if (dresp.done) begin
               d_in = qv[28:0];
               if (qv == '0) begin
                  fail = 1'b1;
               end else begin
                  dreq_in  = '{go: 1'b1, num: DIV_W'(scale_ff), den: DIV_W'(qv[28:0])};
                  state_in = S_PER;
               end
            end
         end
         S_PER: begin
            if (dresp.done) begin
               per2_in = qv[29:0];
               if (qv == '0) begin
                  fail = 1'b1;
               end else begin
                  dreq_in  = '{go: 1'b1, num: DIV_W'(scale_ff), den: DIV_W'(qv[29:0])};
                  state_in = S_ACT;
               end
            end
         end
         S_ACT: begin
            if (dresp.done) begin
               act_in   = qv[29:0];
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if ({2'b0, per2_ff} < target_ff || {act_ff, 8'b0} > {2'b0, q_ff}) begin
               dreq_in  = '{go: 1'b1, num: DIV_W'(a_ff), den: DIV_W'(d_ff)};
               state_in = S_AD;
            end else begin
               ok_in    = 1'b1;
               state_in = S_OUT;
            end
         end
         S_AD: begin
            if (dresp.done) begin
               p_in     = qv[31:0] + 32'd1;
               dreq_in  = '{go: 1'b1, num: DIV_W'(a_ff),
                            den: DIV_W'(qv[31:0] + 32'd1)};
               state_in = S_D;
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (fail) begin
         pre_in   = '0;
         p_in     = '0;
         act_in   = '0;
         ok_in    = 1'b0;
         dreq_in  = '{go: 1'b0, num: dreq_ff.num, den: dreq_ff.den};
         state_in = S_OUT;
      end
   end

   always_ff @(posedge clock) begin
      q_ff      <= q_in;
      scale_ff  <= scale_in;
      target_ff <= target_in;
      p_ff      <= p_in;
      pre_ff    <= pre_in;
      mhz_ff    <= mhz_in;
      a_ff      <= a_in;
      d_ff      <= d_in;
      per2_ff   <= per2_in;
      act_ff    <= act_in;
      prod_ff   <= prod_in;
      big_ff    <= big_in;
      ok_ff     <= ok_in;
      dreq_ff.num <= dreq_in.num;
      dreq_ff.den <= dreq_in.den;
      if (reset) begin
         state_ff   <= S_IDLE;
         dreq_ff.go <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dreq_ff.go <= dreq_in.go;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_ff  <= 29'd84000000;
         maxm_ff <= 9'd168;
         is32_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIMER_CLOCK: clk_ff  <= csr_wdata[28:0];
            CSR_MAX_CLOCK:   maxm_ff <= csr_wdata[8:0];
            CSR_TIMER_32BIT: is32_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign req.ready          = state_ff == S_IDLE;
   assign rsp.valid          = state_ff == S_OUT;
   assign rsp.prescaler      = pre_ff[16:0];
   assign rsp.period_count   = p_ff;
   assign rsp.actual_freq_hz = act_ff;
   assign rsp.ok             = ok_ff;

   assign rsp_set  = rsp.prescaler != '0 && rsp.period_count != '0;
   assign rsp_zero = rsp.prescaler == '0 && rsp.period_count == '0 &&
                     rsp.actual_freq_hz == '0;
   assign div_wait = state_ff inside {S_TGT, S_PRE, S_MHZ, S_PDIV, S_A, S_D, S_PER,
                                      S_ACT, S_AD};

   `PPS_ASSERT(a_ok_nonzero, clock, reset, rsp.valid && rsp.ok |-> rsp_set, "ok item zeroed")
   `PPS_ASSERT(a_fail_zero, clock, reset, rsp.valid && !rsp.ok |-> rsp_zero, "failed item set")
   `PPS_ASSERT(a_one_item, clock, reset, req.valid && req.ready |=> !req.ready, "item while busy")
   `PPS_ASSERT(a_div_wait, clock, reset, dresp.done |-> div_wait, "quotient outside a wait state")
endmodule
